FILE: hw/rtl/bgis_pkg.sv
// Package with the types and constants shared by the gap insertion sorter.
`default_nettype none
package bgis_pkg;
    localparam int DEPTH    = 64;
    localparam int KEY_BITS = 32;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic                is_last;
    } in_item_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] sorted_key;
        logic                end_of_run;
        logic                overflow;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_HOLD,
        ST_CMP,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

    function automatic logic key_less(input logic [KEY_BITS-1:0] x,
                                      input logic [KEY_BITS-1:0] y,
                                      input logic                sgn);
        logic [KEY_BITS-1:0] xa;
        logic [KEY_BITS-1:0] ya;
        begin
            xa = x ^ {sgn, {(KEY_BITS-1){1'b0}}};
            ya = y ^ {sgn, {(KEY_BITS-1){1'b0}}};
            return xa < ya;
        end
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/bgis_ram.sv
// Single-port-write, registered-read memory holding the keys of one set.
`default_nettype none
module bgis_ram #(
    parameter int WIDTH   = 32,
    parameter int ENTRIES = 64,
    parameter int AW      = $clog2(ENTRIES)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/block_gap_insertion_sorter.sv
// Top level of the key sorter: load control, insertion sort sequencer and emission.
//
//  Channel  | Signals                       | Direction
//  input    | in_valid, in_ready, in_data   | keys in, is_last closes a set
//  output   | out_valid, out_ready, out_data| sorted keys, ascending
//  config   | cfg_we, cfg_wdata             | compare_signed
//
// Keys load at one per cycle while in the load state. After the last key the set
// of n keys is sorted in place by insertion sort through the one memory read port:
// each key is fetched, held and compared, each element move adds a compare, and a
// key reaching the front adds a place step. Results stall while out_ready is low.
// Reset clears the counters and state; the memory is not cleared.
`default_nettype none
module block_gap_insertion_sorter (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire bgis_pkg::in_item_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output bgis_pkg::out_item_t    out_data,
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata
);
    import bgis_pkg::*;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                drop_reg, drop_next;
    logic [CNT_W-1:0]    b_reg, b_next;
    logic [ADDR_W-1:0]   c_reg, c_next;
    logic [KEY_BITS-1:0] held_reg, held_next;
    logic                sgn_reg;
    logic                ov_reg, ov_next;
    out_item_t           out_reg, out_next;

    logic                we;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [KEY_BITS-1:0] wdata, rdata;

    bgis_ram #(.WIDTH(KEY_BITS), .ENTRIES(DEPTH)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            b_reg     <= '0;
            c_reg     <= '0;
            sgn_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            b_reg     <= b_next;
            c_reg     <= c_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                sgn_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        held_next  = held_reg;
        ov_next    = ov_reg;
        out_next   = out_reg;
        we         = 1'b0;
        waddr      = c_reg;
        wdata      = held_reg;
        raddr      = c_reg - ADDR_W'(1);
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (count_reg < CNT_W'(DEPTH))
                    begin
                        we         = 1'b1;
                        waddr      = count_reg[ADDR_W-1:0];
                        wdata      = in_data.key;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (in_data.is_last)
                    begin
                        b_next     = CNT_W'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                raddr = b_reg[ADDR_W-1:0];
                c_next = b_reg[ADDR_W-1:0];
                if (b_reg >= count_reg)
                begin
                    b_next     = '0;
                    ov_next    = drop_reg;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                held_next  = rdata;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                we = 1'b1;
                if (key_less(held_reg, rdata, sgn_reg))
                begin
                    wdata  = rdata;
                    c_next = c_reg - ADDR_W'(1);
                    raddr  = c_reg - ADDR_W'(2);
                    if (c_reg == ADDR_W'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    b_next     = b_reg + CNT_W'(1);
                    state_next = ST_FETCH;
                end
            end
            ST_PLACE:
            begin
                we         = 1'b1;
                b_next     = b_reg + CNT_W'(1);
                state_next = ST_FETCH;
            end
            ST_EMIT_RD:
            begin
                raddr      = b_reg[ADDR_W-1:0];
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                out_next.sorted_key = rdata;
                out_next.end_of_run = (b_reg + CNT_W'(1)) == count_reg;
                out_next.overflow   = ov_reg;
                state_next          = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (out_reg.end_of_run)
                    begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        b_next     = b_reg + CNT_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign out_data = out_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Key count exceeds capacity.");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("Loading and emitting at once.");
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_reg != '0)
        else $error("Result offered from an empty set.");
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_data.end_of_run) |=> (count_reg == '0 && in_ready))
        else $error("Set not cleared after the final transfer.");
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the gap insertion sorter with a predictor and random stalls.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bgis_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_we;
    logic cfg_wdata;

    in_item_t pending_items[$];
    out_item_t sorted_expect[$];
    logic [KEY_BITS-1:0] set_keys[$];
    logic set_dropped;
    logic signed_mode;
    int error_count;
    int cycle_count;
    int sets_done;
    int keys_seen;
    int burst_left;
    int gap_left;
    int stall_phase;
    bit stimulus_done;

    block_gap_insertion_sorter uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit key_before(logic [KEY_BITS-1:0] a, logic [KEY_BITS-1:0] b);
        logic [KEY_BITS-1:0] sa;
        logic [KEY_BITS-1:0] sb;
        begin
            sa = a ^ {signed_mode, {(KEY_BITS-1){1'b0}}};
            sb = b ^ {signed_mode, {(KEY_BITS-1){1'b0}}};
            return sa < sb;
        end
    endfunction

    // The sorter runs a plain insertion sort over each set, so the same sort here
    // gives the same sequence.
    task automatic predict_set();
        logic [KEY_BITS-1:0] arr[$];
        logic [KEY_BITS-1:0] t;
        out_item_t r;
        int j;
        begin
            arr = set_keys;
            for (int i = 1; i < arr.size(); i++)
            begin
                j = i;
                while (j > 0 && key_before(arr[j], arr[j-1]))
                begin
                    t = arr[j];
                    arr[j] = arr[j-1];
                    arr[j-1] = t;
                    j--;
                end
            end
            for (int i = 0; i < arr.size(); i++)
            begin
                r.sorted_key = arr[i];
                r.end_of_run = (i == arr.size() - 1);
                r.overflow = set_dropped;
                sorted_expect.push_back(r);
            end
            set_keys.delete();
            set_dropped = 1'b0;
            sets_done++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                keys_seen++;
                if (set_keys.size() < DEPTH)
                    set_keys.push_back(in_data.key);
                else
                    set_dropped = 1'b1;
                if (in_data.is_last)
                    predict_set();
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_items.pop_front();
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (sorted_expect.size() == 0)
                begin
                    $display("%0t: unexpected transfer, actual %h", $time, out_data);
                    error_count++;
                end
                else if (out_data !== sorted_expect[0])
                begin
                    $display("%0t: mismatch, expected key %h last %b ovf %b, actual key %h last %b ovf %b",
                        $time, sorted_expect[0].sorted_key, sorted_expect[0].end_of_run,
                        sorted_expect[0].overflow, out_data.sorted_key, out_data.end_of_run,
                        out_data.overflow);
                    error_count++;
                    void'(sorted_expect.pop_front());
                end
                else
                    void'(sorted_expect.pop_front());
            end
            stall_phase <= (stall_phase + 1) % 64;
            out_ready <= (stall_phase < 24) ? 1'b1 : (($urandom_range(0, 3) != 0));
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_set(int n, int mode);
        in_item_t it;
        begin
            for (int i = 0; i < n; i++)
            begin
                case (mode)
                    0: it.key = $urandom();
                    1: it.key = $urandom_range(0, 7);
                    2: it.key = i;
                    3: it.key = n - i;
                    default: it.key = {$urandom_range(0, 1) ? 8'h80 : 8'h7f, 24'(
                        $urandom_range(0, 15))};
                endcase
                it.is_last = (i == n - 1);
                pending_items.push_back(it);
            end
        end
    endtask

    task automatic drain_and_set(logic mode);
        begin
            wait (pending_items.size() == 0 && !in_valid);
            wait (sorted_expect.size() == 0);
            repeat (20) @(posedge clk);
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_wdata <= mode;
            @(posedge clk);
            cfg_we <= 1'b0;
            signed_mode = mode;
        end
    endtask

    initial
    begin
        in_item_t it;
        error_count = 0;
        cycle_count = 0;
        sets_done = 0;
        keys_seen = 0;
        set_dropped = 1'b0;
        signed_mode = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: single key, extremes, equal keys and a reversed set.
        it.key = 32'hffff_ffff; it.is_last = 1'b1; pending_items.push_back(it);
        it.key = 32'h0; it.is_last = 1'b0; pending_items.push_back(it);
        it.key = 32'h8000_0000; pending_items.push_back(it);
        it.key = 32'h7fff_ffff; pending_items.push_back(it);
        it.key = 32'hffff_ffff; it.is_last = 1'b1; pending_items.push_back(it);
        add_set(6, 1);
        add_set(4, 3);
        drain_and_set(1'b1);
        it.key = 32'h0; it.is_last = 1'b0; pending_items.push_back(it);
        it.key = 32'h8000_0000; pending_items.push_back(it);
        it.key = 32'h7fff_ffff; pending_items.push_back(it);
        it.key = 32'hffff_ffff; it.is_last = 1'b1; pending_items.push_back(it);
        add_set(8, 4);
        // Overflow: more keys than the store holds.
        add_set(DEPTH + 3, 0);
        drain_and_set(1'b0);
        for (int s = 0; s < 4; s++)
            add_set($urandom_range(1, 14), $urandom_range(0, 4));
        drain_and_set(1'b1);
        for (int s = 0; s < 3; s++)
            add_set($urandom_range(1, 14), $urandom_range(0, 4));
        drain_and_set(1'b0);
        add_set(8, 0);
        wait (pending_items.size() == 0 && !in_valid);
        wait (sorted_expect.size() == 0);
        repeat (50) @(posedge clk);
        $display("Sorted %0d sets from %0d keys in both compare modes, with overflow sets.",
            sets_done, keys_seen);
        if (error_count == 0 && sorted_expect.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
